// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define EPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("epc assertion failed");

// condition must never be seen at a clock edge out of reset
`define EPC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("epc forbidden condition seen");

`endif

// File: hw/rtl/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Types, constants and helper functions of the encoder PID position control.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam logic [31:0] US_PER_SEC = 32'd1000000;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 8'd0,
    REG_DERIV_GAIN = 8'd1,
    REG_INTEG_GAIN = 8'd2,
    REG_MAX_DUTY   = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic        start;
    unit_op_e    op;
    logic        neg;
    logic [63:0] a;
    logic [31:0] b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
    logic [63:0] quo;
    logic [31:0] rem;
  } unit_rsp_t;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/epc_if.sv
// ----------------------------------------------------------------------------
// epc channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface epc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               enc_b_level;
  logic signed [15:0] target_offset;
  logic [31:0]        timestamp_us;
  logic [8:0]         duty_scale;

  modport source(output valid, operation, enc_b_level, target_offset, timestamp_us,
                 duty_scale, input ready);
  modport sink(input valid, operation, enc_b_level, target_offset, timestamp_us,
               duty_scale, output ready);
endinterface

interface epc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       drive_a;
  logic       drive_b;

  modport source(output valid, duty, drive_a, drive_b, input ready);
  modport sink(input valid, duty, drive_a, drive_b, output ready);
endinterface

interface epc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [epc_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/epc_serial_unit.sv
// ----------------------------------------------------------------------------
// epc_serial_unit
// Bit-serial multiplier (32 steps, saturating signed 64-bit result) and
// restoring divider (64 steps, 64-bit dividend, 32-bit divisor).
// ----------------------------------------------------------------------------
module epc_serial_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  epc_pkg::unit_req_t  req_i,
  output epc_pkg::unit_rsp_t  rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [6:0]         cnt_q;
  epc_pkg::unit_op_e  op_q;
  logic               neg_q;
  logic [63:0]        a_q;
  logic [31:0]        b_q;
  logic [63:0]        hi_q;
  logic [31:0]        lo_q;

  logic [64:0]        mul_sum;
  logic [32:0]        div_t;
  logic [32:0]        div_diff;
  logic               div_ge;
  logic [95:0]        prod_full;
  logic               big;

  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
  assign div_t    = {lo_q, hi_q[63]};
  assign div_ge   = div_t >= {1'b0, b_q};
  assign div_diff = div_t - {1'b0, b_q};

  assign prod_full = {hi_q, lo_q};
  assign big       = |prod_full[95:64];

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.quo  = hi_q;
    rsp_o.rem  = lo_q;
    if (neg_q) begin
      if (big || (prod_full[63] && (|prod_full[62:0]))) begin
        rsp_o.prod = {1'b1, 63'd0};
      end else begin
        rsp_o.prod = ~prod_full[63:0] + 64'd1;
      end
    end else begin
      if (big || prod_full[63]) begin
        rsp_o.prod = {1'b0, {63{1'b1}}};
      end else begin
        rsp_o.prod = prod_full[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= epc_pkg::OP_MUL;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        neg_q  <= req_i.neg;
        cnt_q  <= (req_i.op == epc_pkg::OP_MUL) ? 7'd32 : 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      if (req_i.op == epc_pkg::OP_MUL) begin
        hi_q <= '0;
        lo_q <= req_i.b;
      end else begin
        hi_q <= req_i.a;
        lo_q <= '0;
      end
    end else if (busy_q) begin
      unique case (op_q)
        epc_pkg::OP_MUL: begin
          hi_q <= mul_sum[64:1];
          lo_q <= {mul_sum[0], lo_q[31:1]};
        end
        epc_pkg::OP_DIV: begin
          lo_q <= div_ge ? div_diff[31:0] : div_t[31:0];
          hi_q <= {hi_q[62:0], div_ge};
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/encoder_pid_position_control.sv
// An encoder edge updates the position count and leaves the input ready; a
// control tick runs a sequence of six 32-step serial multiplies and three
// 64-step serial divides on one shared shift-add/restoring unit, and the
// input stays not-ready until its result is loaded into the output
// register. The output register holds one result, so a new item is taken
// while the previous result waits. Register writes are always accepted;
// indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
// encoder_pid_position_control
// Quadrature position count with a fixed-point PID position loop.
// ----------------------------------------------------------------------------
module encoder_pid_position_control (
  input  logic           clk_i,
  input  logic           rst_ni,
  epc_in_if.sink         in_i,
  epc_out_if.source      out_o,
  epc_cfg_if.sink        cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_DIFF,
    S_D_RATE,
    S_M_EDT,
    S_D_INT,
    S_M_KIR,
    S_D_KIR,
    S_M_KIQ,
    S_M_KP,
    S_M_KD,
    S_SUM,
    S_OUT
  } state_e;

  state_e              state_q;
  logic                pend_q;

  logic [31:0]         kp_q, kd_q, ki_q;
  logic [7:0]          max_duty_q;

  logic [31:0]         pos_q;
  logic [15:0]         prev_err_q;
  logic [63:0]         integ_q;
  logic [31:0]         prev_time_q;

  logic [15:0]         e_q;
  logic [31:0]         dt_q;
  logic [8:0]          scale_q;
  logic [16:0]         diff_q;
  logic [63:0]         num_q;
  logic [63:0]         rate_q;
  logic [63:0]         q_mag_q;
  logic [19:0]         r_mag_q;
  logic                qr_neg_q;
  logic [63:0]         bterm_q;
  logic [63:0]         iterm_q;
  logic [63:0]         acc_q;
  logic [63:0]         u_q;

  logic                out_valid_q;
  logic [7:0]          duty_q;
  logic                drive_a_q;

  epc_pkg::unit_req_t  req;
  epc_pkg::unit_rsp_t  rsp;

  logic                in_acc;
  logic [31:0]         dt_raw;
  logic [16:0]         diff_new;
  logic [63:0]         quo_signed;
  logic [63:0]         mu;
  logic [63:0]         mag;
  logic [7:0]          mag8;
  logic [16:0]         scaled;
  logic [8:0]          duty_wide;
  logic [7:0]          duty_new;

  epc_serial_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.duty    = duty_q;
  assign out_o.drive_a = drive_a_q;
  assign out_o.drive_b = ~drive_a_q;

  assign dt_raw   = in_i.timestamp_us - prev_time_q;
  assign diff_new = {in_i.target_offset[15], in_i.target_offset}
                  - {prev_err_q[15], prev_err_q};

  assign quo_signed = num_q[63] ? (~rsp.quo + 64'd1) : rsp.quo;

  assign mu        = epc_pkg::abs64(u_q);
  assign mag       = mu >> epc_pkg::GAIN_FRAC_BITS;
  assign mag8      = (mag > {56'd0, max_duty_q}) ? max_duty_q : mag[7:0];
  assign scaled    = {9'd0, mag8} * {8'd0, scale_q};
  assign duty_wide = scaled[16:8];
  assign duty_new  = duty_wide[8] ? 8'hFF : duty_wide[7:0];

  always_comb begin
    req.start = 1'b0;
    req.op    = epc_pkg::OP_MUL;
    req.neg   = 1'b0;
    req.a     = '0;
    req.b     = '0;
    unique case (state_q)
      S_M_DIFF: begin
        req.a   = {47'd0, (diff_q[16] ? (~diff_q + 17'd1) : diff_q)};
        req.b   = epc_pkg::US_PER_SEC;
        req.neg = diff_q[16];
      end
      S_D_RATE: begin
        req.op = epc_pkg::OP_DIV;
        req.a  = epc_pkg::abs64(num_q);
        req.b  = dt_q;
      end
      S_M_EDT: begin
        req.a   = {48'd0, (e_q[15] ? (~e_q + 16'd1) : e_q)};
        req.b   = dt_q;
        req.neg = e_q[15];
      end
      S_D_INT: begin
        req.op = epc_pkg::OP_DIV;
        req.a  = epc_pkg::abs64(integ_q);
        req.b  = epc_pkg::US_PER_SEC;
      end
      S_M_KIR: begin
        req.a   = {44'd0, r_mag_q};
        req.b   = ki_q[31] ? (~ki_q + 32'd1) : ki_q;
        req.neg = ki_q[31] ^ qr_neg_q;
      end
      S_D_KIR: begin
        req.op = epc_pkg::OP_DIV;
        req.a  = epc_pkg::abs64(num_q);
        req.b  = epc_pkg::US_PER_SEC;
      end
      S_M_KIQ: begin
        req.a   = q_mag_q;
        req.b   = ki_q[31] ? (~ki_q + 32'd1) : ki_q;
        req.neg = ki_q[31] ^ qr_neg_q;
      end
      S_M_KP: begin
        req.a   = {48'd0, (e_q[15] ? (~e_q + 16'd1) : e_q)};
        req.b   = kp_q[31] ? (~kp_q + 32'd1) : kp_q;
        req.neg = kp_q[31] ^ e_q[15];
      end
      S_M_KD: begin
        req.a   = epc_pkg::abs64(rate_q);
        req.b   = kd_q[31] ? (~kd_q + 32'd1) : kd_q;
        req.neg = kd_q[31] ^ rate_q[63];
      end
      default: ;
    endcase
    req.start = (state_q != S_IDLE) && (state_q != S_SUM) && (state_q != S_OUT) && !pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      kd_q        <= '0;
      ki_q        <= '0;
      max_duty_q  <= 8'hFF;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        epc_pkg::REG_PROP_GAIN:  kp_q       <= cfg_i.data;
        epc_pkg::REG_DERIV_GAIN: kd_q       <= cfg_i.data;
        epc_pkg::REG_INTEG_GAIN: ki_q       <= cfg_i.data;
        epc_pkg::REG_MAX_DUTY:   max_duty_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      pos_q       <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      prev_time_q <= '0;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
      drive_a_q   <= 1'b1;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (req.start) begin
        pend_q <= 1'b1;
      end else if (rsp.done) begin
        pend_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_i.operation) begin
              pos_q <= in_i.enc_b_level ? (pos_q + 32'd1) : (pos_q - 32'd1);
            end else begin
              e_q         <= in_i.target_offset;
              dt_q        <= (dt_raw == 32'd0) ? 32'd1 : dt_raw;
              scale_q     <= in_i.duty_scale;
              diff_q      <= diff_new;
              prev_err_q  <= in_i.target_offset;
              prev_time_q <= in_i.timestamp_us;
              state_q     <= S_M_DIFF;
            end
          end
        end
        S_M_DIFF: if (rsp.done) begin
          num_q   <= rsp.prod;
          state_q <= S_D_RATE;
        end
        S_D_RATE: if (rsp.done) begin
          rate_q  <= quo_signed;
          state_q <= S_M_EDT;
        end
        S_M_EDT: if (rsp.done) begin
          integ_q <= epc_pkg::sat_add64(integ_q, rsp.prod);
          state_q <= S_D_INT;
        end
        S_D_INT: if (rsp.done) begin
          q_mag_q  <= rsp.quo;
          r_mag_q  <= rsp.rem[19:0];
          qr_neg_q <= integ_q[63];
          state_q  <= S_M_KIR;
        end
        S_M_KIR: if (rsp.done) begin
          num_q   <= rsp.prod;
          state_q <= S_D_KIR;
        end
        S_D_KIR: if (rsp.done) begin
          bterm_q <= quo_signed;
          state_q <= S_M_KIQ;
        end
        S_M_KIQ: if (rsp.done) begin
          iterm_q <= epc_pkg::sat_add64(rsp.prod, bterm_q);
          state_q <= S_M_KP;
        end
        S_M_KP: if (rsp.done) begin
          acc_q   <= rsp.prod;
          state_q <= S_M_KD;
        end
        S_M_KD: if (rsp.done) begin
          acc_q   <= epc_pkg::sat_add64(acc_q, rsp.prod);
          state_q <= S_SUM;
        end
        S_SUM: begin
          u_q     <= epc_pkg::sat_add64(acc_q, iterm_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            duty_q      <= duty_new;
            drive_a_q   <= ~u_q[63];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/epc_checker.sv
// ----------------------------------------------------------------------------
// epc_checker
// Port-level checks of the encoder PID position control, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_operation_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_drive_a_i,
  input logic out_drive_b_i
);

  `EPC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)
  `EPC_ASSERT_NEVER(a_drive_excl, clk_i, rst_ni, out_valid_i && (out_drive_a_i == out_drive_b_i))
  `EPC_ASSERT(a_tick_busy, clk_i, rst_ni, (in_valid_i && in_ready_i && in_operation_i) |=> !in_ready_i)
  `EPC_ASSERT(a_edge_fast, clk_i, rst_ni, (in_valid_i && in_ready_i && !in_operation_i) |=> in_ready_i)

endmodule

bind encoder_pid_position_control epc_checker u_epc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_drive_a_i  (out_o.drive_a),
  .out_drive_b_i  (out_o.drive_b)
);
